// ===== rtl/lrmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrmt_pkg
// Shared types and constants for the linear recurrence modular term unit.
// ----------------------------------------------------------------------------
package lrmt_pkg;

	// Configuration port geometry.
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	// Register indexes, taken from paddr[4:2].
	localparam logic [REG_IDX_W-1:0] REG_COEF_P      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_Q      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_TERM  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_TERM = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MODULUS     = 3'd4;

	// Register reset values.
	localparam int unsigned COEF_P_RESET      = 1;
	localparam int unsigned COEF_Q_RESET      = 1;
	localparam int unsigned FIRST_TERM_RESET  = 1;
	localparam int unsigned SECOND_TERM_RESET = 1;
	localparam int unsigned MODULUS_RESET     = 1000000007;

	// Sequencer of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_ROUND,
		ST_FINAL,
		ST_DELIVER
	} lrmt_state_t;

	// Sequencer of one matrix multiplier.
	typedef enum logic [1:0] {
		MM_IDLE,
		MM_RUN,
		MM_SUM
	} mm_state_t;

endpackage

// ===== rtl/lrmt_lane.sv =====
// ----------------------------------------------------------------------------
// lrmt_lane
// Bit-serial modular multiplier lane. The serial operand enters one bit per
// cycle while en is high, most significant bit first; the parallel operand must be below m
// (or equal to one). The running remainder always stays below m.
// ----------------------------------------------------------------------------
module lrmt_lane #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         clr,
	input  logic         en,
	input  logic         sbit,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic [W-1:0] r
);

	logic [W-1:0] r_q;
	logic [W+1:0] t;
	logic [W+2:0] d1;
	logic [W+2:0] d2;
	logic [W-1:0] r_next;

	// Double the remainder, add the operand if the bit is set, and take off
	// twice m, m or nothing; the sum is always below three times m.
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + {2'b00, (sbit ? b : {W{1'b0}})};
		d1 = {1'b0, t} - {3'b000, m};
		d2 = {1'b0, t} - {2'b00, m, 1'b0};
		if (!d2[W+2]) begin
			r_next = d2[W-1:0];
		end else if (!d1[W+2]) begin
			r_next = d1[W-1:0];
		end else begin
			r_next = t[W-1:0];
		end
	end

	// Remainder register.
	always_ff @(posedge clk) begin
		if (clr) begin
			r_q <= '0;
		end else if (en) begin
			r_q <= r_next;
		end
	end

	assign r = r_q;

endmodule

// ===== rtl/lrmt_matmul.sv =====
// ----------------------------------------------------------------------------
// lrmt_matmul
// 2x2 modular matrix product C = A*B mod m. Eight bit-serial lanes form the
// partial products bit by bit, then the pairs are added modulo m.
// ----------------------------------------------------------------------------
module lrmt_matmul #(
	parameter int W = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0][1:0][W-1:0] a,
	input  logic [1:0][1:0][W-1:0] b,
	input  logic [W-1:0]           m,
	output logic [1:0][1:0][W-1:0] c,
	output logic                   done
);

	localparam int CW = $clog2(W);

	lrmt_pkg::mm_state_t state_q;
	lrmt_pkg::mm_state_t state_d;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic run;
	logic [1:0][1:0][W-1:0] a_sh_q;
	logic [1:0][1:0][W-1:0] b_q;
	logic [1:0][1:0][W-1:0] c_q;
	logic [W-1:0] m_q;
	logic [1:0][1:0][1:0][W-1:0] r_lane;
	logic [1:0][1:0][W-1:0] sum_mod;

	// Next state: run through every bit of the A entries, then take the pair sums.
	always_comb begin
		state_d = state_q;
		run     = 1'b0;
		unique case (state_q)
			lrmt_pkg::MM_IDLE: begin
				if (start) begin
					state_d = lrmt_pkg::MM_RUN;
				end
			end
			lrmt_pkg::MM_RUN: begin
				run = 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					state_d = lrmt_pkg::MM_SUM;
				end
			end
			lrmt_pkg::MM_SUM: begin
				state_d = lrmt_pkg::MM_IDLE;
			end
			default: begin
				state_d = lrmt_pkg::MM_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrmt_pkg::MM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == lrmt_pkg::MM_SUM);
			if (start) begin
				cnt_q <= '0;
			end else if (run) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Operand capture and serial shift of the A entries.
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= a;
			b_q    <= b;
			m_q    <= m;
		end else if (run) begin
			for (int i = 0; i < 2; i++) begin
				for (int k = 0; k < 2; k++) begin
					a_sh_q[i][k] <= {a_sh_q[i][k][W-2:0], 1'b0};
				end
			end
		end
		if (state_q == lrmt_pkg::MM_SUM) begin
			c_q <= sum_mod;
		end
	end

	// Lane (i, j, k) forms A[i][k] * B[k][j] mod m.
	for (genvar i = 0; i < 2; i++) begin : g_row
		for (genvar j = 0; j < 2; j++) begin : g_col
			for (genvar k = 0; k < 2; k++) begin : g_term
				lrmt_lane #(
					.W(W)
				) u_lane (
					.clk (clk),
					.clr (start),
					.en  (run),
					.sbit(a_sh_q[i][k][W-1]),
					.b   (b_q[k][j]),
					.m   (m_q),
					.r   (r_lane[i][j][k])
				);
			end

			// Pair sum, both terms below m, so one subtraction suffices.
			logic [W:0]   s;
			logic [W+1:0] d;
			always_comb begin
				s = {1'b0, r_lane[i][j][0]} + {1'b0, r_lane[i][j][1]};
				d = {1'b0, s} - {2'b00, m_q};
				sum_mod[i][j] = d[W+1] ? s[W-1:0] : d[W-1:0];
			end
		end
	end

	assign c    = c_q;
	assign done = done_q;

endmodule

// ===== rtl/linear_recurrence_modular_term_unit.sv =====
// ----------------------------------------------------------------------------
// linear_recurrence_modular_term_unit
// Indexes 0, 1, 2 and a zero modulus are answered without arithmetic;
// otherwise the bit-serial matrix multipliers run one round per bit of
// index - 2. One request is worked on at a time; the next one is taken as
// soon as the result sits in the output register. Reset restores the
// configuration registers to their reset values and returns the sequencers
// to idle at once; the working matrices and result are not reset.
// ----------------------------------------------------------------------------
module linear_recurrence_modular_term_unit #(
	parameter int VALUE_BITS = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lrmt_pkg::ADDR_W-1:0] paddr,
	input  logic [lrmt_pkg::DATA_W-1:0] pwdata,
	output logic [lrmt_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [VALUE_BITS-1:0]       term_index,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [VALUE_BITS-1:0]       term_value
);

	localparam int W = VALUE_BITS;
	localparam logic [W-1:0] MOD_RESET = W'(lrmt_pkg::MODULUS_RESET);

	lrmt_pkg::lrmt_state_t state_q;
	lrmt_pkg::lrmt_state_t state_d;

	logic [W-1:0] coef_p_q;
	logic [W-1:0] coef_q_q;
	logic [W-1:0] first_q;
	logic [W-1:0] second_q;
	logic [W-1:0] modulus_q;

	logic [W-1:0] k_q;
	logic [1:0][1:0][W-1:0] acc_q;
	logic [1:0][1:0][W-1:0] base_q;
	logic [W-1:0] a1r_q;
	logic [W-1:0] a2r_q;
	logic [W-1:0] result_q;
	logic [W-1:0] term_value_q;
	logic rsp_valid_q;
	logic u_start_q;
	logic v_start_q;
	logic u_start_d;
	logic v_start_d;

	logic cfg_wr;
	logic [lrmt_pkg::REG_IDX_W-1:0] reg_idx;
	logic req_acc;
	logic shortcut;
	logic out_free;
	logic [W-1:0] one_val;

	logic [1:0][1:0][W-1:0] v_a;
	logic [1:0][1:0][W-1:0] v_b;
	logic [1:0][1:0][W-1:0] u_c;
	logic [1:0][1:0][W-1:0] v_c;
	logic u_done;
	logic v_done;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[lrmt_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_p_q  <= W'(lrmt_pkg::COEF_P_RESET);
			coef_q_q  <= W'(lrmt_pkg::COEF_Q_RESET);
			first_q   <= W'(lrmt_pkg::FIRST_TERM_RESET);
			second_q  <= W'(lrmt_pkg::SECOND_TERM_RESET);
			modulus_q <= MOD_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lrmt_pkg::REG_COEF_P:      coef_p_q  <= pwdata[W-1:0];
				lrmt_pkg::REG_COEF_Q:      coef_q_q  <= pwdata[W-1:0];
				lrmt_pkg::REG_FIRST_TERM:  first_q   <= pwdata[W-1:0];
				lrmt_pkg::REG_SECOND_TERM: second_q  <= pwdata[W-1:0];
				lrmt_pkg::REG_MODULUS:     modulus_q <= pwdata[W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			lrmt_pkg::REG_COEF_P:      prdata = lrmt_pkg::DATA_W'(coef_p_q);
			lrmt_pkg::REG_COEF_Q:      prdata = lrmt_pkg::DATA_W'(coef_q_q);
			lrmt_pkg::REG_FIRST_TERM:  prdata = lrmt_pkg::DATA_W'(first_q);
			lrmt_pkg::REG_SECOND_TERM: prdata = lrmt_pkg::DATA_W'(second_q);
			lrmt_pkg::REG_MODULUS:     prdata = lrmt_pkg::DATA_W'(modulus_q);
			default:                   prdata = '0;
		endcase
	end

	// Request decode: small indexes and a zero modulus need no arithmetic.
	assign req_ready = (state_q == lrmt_pkg::ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign shortcut  = (term_index < W'(3)) || (modulus_q == '0);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign one_val   = W'(modulus_q != W'(1));

	// Sequencer: reduce the inputs, one round per exponent bit, then apply
	// the power to the two given terms.
	always_comb begin
		state_d   = state_q;
		u_start_d = 1'b0;
		v_start_d = 1'b0;
		unique case (state_q)
			lrmt_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (shortcut) begin
						state_d = lrmt_pkg::ST_DELIVER;
					end else begin
						state_d   = lrmt_pkg::ST_REDUCE;
						v_start_d = 1'b1;
					end
				end
			end
			lrmt_pkg::ST_REDUCE: begin
				if (v_done) begin
					state_d   = lrmt_pkg::ST_ROUND;
					u_start_d = 1'b1;
					v_start_d = 1'b1;
				end
			end
			lrmt_pkg::ST_ROUND: begin
				if (v_done && u_done) begin
					v_start_d = 1'b1;
					if (k_q[W-1:1] == '0) begin
						state_d = lrmt_pkg::ST_FINAL;
					end else begin
						u_start_d = 1'b1;
					end
				end
			end
			lrmt_pkg::ST_FINAL: begin
				if (v_done) begin
					state_d = lrmt_pkg::ST_DELIVER;
				end
			end
			lrmt_pkg::ST_DELIVER: begin
				if (out_free) begin
					state_d = lrmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrmt_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrmt_pkg::ST_IDLE;
			u_start_q   <= 1'b0;
			v_start_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			u_start_q <= u_start_d;
			v_start_q <= v_start_d;
			if (state_q == lrmt_pkg::ST_DELIVER && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working matrices, exponent and result.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			k_q <= term_index - W'(2);
			if (term_index == W'(1)) begin
				result_q <= first_q;
			end else if (term_index == W'(2)) begin
				result_q <= second_q;
			end else begin
				result_q <= '0;
			end
		end
		if (state_q == lrmt_pkg::ST_REDUCE && v_done) begin
			base_q[0][0] <= v_c[0][0];
			base_q[0][1] <= v_c[0][1];
			base_q[1][0] <= one_val;
			base_q[1][1] <= '0;
			acc_q[0][0]  <= one_val;
			acc_q[0][1]  <= '0;
			acc_q[1][0]  <= '0;
			acc_q[1][1]  <= one_val;
			a1r_q        <= v_c[1][0];
			a2r_q        <= v_c[1][1];
		end
		if (state_q == lrmt_pkg::ST_ROUND && v_done && u_done) begin
			if (k_q[0]) begin
				acc_q <= u_c;
			end
			base_q <= v_c;
			k_q    <= k_q >> 1;
		end
		if (state_q == lrmt_pkg::ST_FINAL && v_done) begin
			result_q <= v_c[0][0];
		end
		if (state_q == lrmt_pkg::ST_DELIVER && out_free) begin
			term_value_q <= result_q;
		end
	end

	// Operands of the shared multiplier: input reduction, squaring, final step.
	always_comb begin
		v_a = base_q;
		v_b = base_q;
		case (state_q)
			lrmt_pkg::ST_REDUCE: begin
				v_a[0][0] = coef_p_q;
				v_a[0][1] = coef_q_q;
				v_a[1][0] = first_q;
				v_a[1][1] = second_q;
				v_b[0][0] = W'(1);
				v_b[0][1] = '0;
				v_b[1][0] = '0;
				v_b[1][1] = W'(1);
			end
			lrmt_pkg::ST_FINAL: begin
				v_a       = acc_q;
				v_b[0][0] = a2r_q;
				v_b[0][1] = '0;
				v_b[1][0] = a1r_q;
				v_b[1][1] = '0;
			end
			default: begin
			end
		endcase
	end

	// Accumulating multiplier: acc * base.
	lrmt_matmul #(
		.W(W)
	) u_acc_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (u_start_q),
		.a     (acc_q),
		.b     (base_q),
		.m     (modulus_q),
		.c     (u_c),
		.done  (u_done)
	);

	// Shared multiplier: reduction, squaring of base, final product.
	lrmt_matmul #(
		.W(W)
	) u_sq_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (v_start_q),
		.a     (v_a),
		.b     (v_b),
		.m     (modulus_q),
		.c     (v_c),
		.done  (v_done)
	);

	assign rsp_valid  = rsp_valid_q;
	assign term_value = term_value_q;

endmodule

// ===== dv/lrmt_checker.sv =====
// ----------------------------------------------------------------------------
// lrmt_checker
// Watches the register port and the request and response channels of the linear
// recurrence term unit. It keeps its own copy of the registers, works out the
// expected term for every accepted request by raising the companion matrix to
// a power, and compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module lrmt_checker #(
	parameter int VALUE_BITS = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrmt_pkg::ADDR_W-1:0]   paddr,
	input  logic [lrmt_pkg::DATA_W-1:0]   pwdata,
	input  logic                          pready,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic [VALUE_BITS-1:0]         term_index,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [VALUE_BITS-1:0]         term_value,
	output int                            fail_count,
	output int                            outstanding
);

	// A 2x2 matrix, entry (i, j) at position i*2 + j.
	typedef logic [3:0][63:0] mat_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] index;
		logic [VALUE_BITS-1:0] value;
	} term_rec_t;

	logic [63:0] cur_p;
	logic [63:0] cur_q;
	logic [63:0] cur_first;
	logic [63:0] cur_second;
	logic [63:0] cur_modulus;
	term_rec_t   pending_terms[$];
	int          fails;

	assign fail_count = fails;

	// Product of two matrices; every partial product is reduced at full width,
	// and so is the running sum.
	function automatic mat_t matrix_product_mod(input mat_t a, input mat_t b,
			input logic [63:0] m);
		mat_t        r;
		logic [63:0] sum;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				sum = 64'd0;
				for (int k = 0; k < 2; k++) begin
					sum = (sum + (a[i*2+k] * b[k*2+j]) % m) % m;
				end
				r[i*2+j] = sum;
			end
		end
		return r;
	endfunction

	// Term number n of the recurrence under the current register settings.
	function automatic logic [VALUE_BITS-1:0] term_at(input logic [63:0] n);
		mat_t        acc;
		mat_t        base;
		mat_t        col;
		logic [63:0] k;
		if (n == 64'd0) begin
			return '0;
		end
		if (n == 64'd1) begin
			return cur_first[VALUE_BITS-1:0];
		end
		if (n == 64'd2) begin
			return cur_second[VALUE_BITS-1:0];
		end
		if (cur_modulus == 64'd0) begin
			return '0;
		end
		acc = '0;
		acc[0] = 64'd1;
		acc[3] = 64'd1;
		// The coefficients go in unreduced; the first product reduces them.
		base = '0;
		base[0] = cur_p;
		base[1] = cur_q;
		base[2] = 64'd1;
		k = n - 64'd2;
		while (k != 64'd0) begin
			if (k[0]) begin
				acc = matrix_product_mod(acc, base, cur_modulus);
			end
			base = matrix_product_mod(base, base, cur_modulus);
			k = k >> 1;
		end
		col = '0;
		col[0] = cur_second;
		col[2] = cur_first;
		col = matrix_product_mod(acc, col, cur_modulus);
		return col[0][VALUE_BITS-1:0];
	endfunction

	// Register shadow, expectation store and comparison.
	always @(posedge clk or negedge arst_n) begin
		term_rec_t got;
		if (!arst_n) begin
			cur_p       = 64'(lrmt_pkg::COEF_P_RESET);
			cur_q       = 64'(lrmt_pkg::COEF_Q_RESET);
			cur_first   = 64'(lrmt_pkg::FIRST_TERM_RESET);
			cur_second  = 64'(lrmt_pkg::SECOND_TERM_RESET);
			cur_modulus = 64'(lrmt_pkg::MODULUS_RESET);
			pending_terms.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				unique case (paddr[lrmt_pkg::ADDR_W-1:2])
					lrmt_pkg::REG_COEF_P:
						cur_p       = 64'(pwdata[VALUE_BITS-1:0]);
					lrmt_pkg::REG_COEF_Q:
						cur_q       = 64'(pwdata[VALUE_BITS-1:0]);
					lrmt_pkg::REG_FIRST_TERM:
						cur_first   = 64'(pwdata[VALUE_BITS-1:0]);
					lrmt_pkg::REG_SECOND_TERM:
						cur_second  = 64'(pwdata[VALUE_BITS-1:0]);
					lrmt_pkg::REG_MODULUS:
						cur_modulus = 64'(pwdata[VALUE_BITS-1:0]);
					default: begin
					end
				endcase
			end
			// A result always belongs to an earlier request, so it is taken first.
			if (rsp_valid && rsp_ready) begin
				if (pending_terms.size() == 0) begin
					fails++;
					$display("%0t: result %0d arrived with no request waiting",
						$time, term_value);
				end else begin
					got = pending_terms.pop_front();
					if (term_value !== got.value) begin
						fails++;
						$display("%0t: term %0d: expected %0d, actual %0d",
							$time, got.index, got.value, term_value);
					end
				end
			end
			if (req_valid && req_ready) begin
				pending_terms.push_back('{index: term_index,
					value: term_at(64'(term_index))});
			end
			outstanding <= pending_terms.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the linear recurrence modular term unit. It resets the unit,
// runs a short directed set of indexes under hand-picked register settings,
// then phases of random indexes under random settings, with random gaps on
// both channels. A checker beside the unit predicts and compares every term.
// ----------------------------------------------------------------------------
module tb;

	localparam int VB = 31;
	localparam logic [VB-1:0] MAX_VAL = {VB{1'b1}};
	localparam logic [lrmt_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 70;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [lrmt_pkg::ADDR_W-1:0] paddr = '0;
	logic [lrmt_pkg::DATA_W-1:0] pwdata = '0;
	logic [lrmt_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        req_valid = 1'b0;
	logic                        req_ready;
	logic [VB-1:0]               term_index = '0;
	logic                        rsp_valid;
	logic                        rsp_ready = 1'b0;
	logic [VB-1:0]               term_value;
	logic                        calm = 1'b0;
	int                          fail_count;
	int                          outstanding;

	linear_recurrence_modular_term_unit #(
		.VALUE_BITS(VB)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.term_index (term_index),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.term_value (term_value)
	);

	lrmt_checker #(
		.VALUE_BITS(VB)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.term_index  (term_index),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.term_value  (term_value),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver stalls in about a quarter of the cycles, except while calm.
	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(99) >= 24);
	end

	// Register write: a setup phase, an access phase held until pready, then a quiet phase.
	task automatic write_reg(input logic [lrmt_pkg::REG_IDX_W-1:0] idx,
			input logic [lrmt_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One request; valid stays high afterwards until the next request or a drain.
	task automatic send_term(input logic [VB-1:0] idx);
		while (!calm && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		term_index <= idx;
		do @(posedge clk); while (!req_ready);
	endtask

	// Hold the sender back until every expected term has come.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Bit lengths spread evenly up to VB, now and then the smallest indexes.
	function automatic logic [VB-1:0] draw_index();
		int unsigned   len;
		logic [VB-1:0] mask;
		if ($urandom_range(7) == 0) begin
			return VB'($urandom_range(1, 5));
		end
		len  = $urandom_range(1, VB);
		mask = MAX_VAL >> (VB - len);
		return (VB'($urandom) & mask) | (VB'(1) << (len - 1));
	endfunction

	// Coefficients and starting terms, extremes included; bit 31 is sometimes set.
	function automatic logic [lrmt_pkg::DATA_W-1:0] draw_operand();
		case ($urandom_range(5))
			0: return '0;
			1: return 32'd1;
			2: return {1'b0, MAX_VAL};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [lrmt_pkg::DATA_W-1:0] draw_modulus();
		case ($urandom_range(4))
			0: return {1'b0, MAX_VAL};
			1: return $urandom_range(2, 1000);
			2: return 32'd1;
			default: return $urandom_range(1, 32'h7fff_ffff);
		endcase
	endfunction

	// Cycles in which nothing is accepted anywhere end the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
					(psel && penable && pready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the Fibonacci sequence modulo 1000000007.
		send_term(VB'(1));
		send_term(VB'(2));
		send_term(VB'(3));
		send_term(VB'(4));
		send_term(VB'(12));
		send_term(VB'(0));
		send_term(MAX_VAL);
		send_term(VB'(1) << (VB - 1));
		send_term(VB'(5));
		wait_drained();

		// Every register at its largest; a write to an unused address is ignored.
		write_reg(lrmt_pkg::REG_COEF_P, {1'b0, MAX_VAL});
		write_reg(lrmt_pkg::REG_COEF_Q, {1'b0, MAX_VAL});
		write_reg(lrmt_pkg::REG_FIRST_TERM, {1'b0, MAX_VAL});
		write_reg(lrmt_pkg::REG_SECOND_TERM, 32'hffff_ffff);
		write_reg(lrmt_pkg::REG_MODULUS, {1'b0, MAX_VAL});
		write_reg(REG_UNUSED, 32'd12345);
		send_term(VB'(3));
		send_term(VB'(4));
		send_term(MAX_VAL);
		send_term(VB'(32'h2aaa_aaaa));
		send_term(VB'(32'h5555_5555));
		wait_drained();

		// Modulus one: everything from term three on is zero; terms one and two stay raw.
		write_reg(lrmt_pkg::REG_MODULUS, 32'd1);
		send_term(VB'(1));
		send_term(VB'(2));
		send_term(VB'(3));
		send_term(VB'(1000));
		wait_drained();

		// Modulus zero: only terms one and two are non-zero.
		write_reg(lrmt_pkg::REG_MODULUS, 32'd0);
		send_term(VB'(3));
		send_term(MAX_VAL);
		send_term(VB'(1));
		wait_drained();

		// Zero coefficients with a small prime modulus.
		write_reg(lrmt_pkg::REG_COEF_P, 32'd0);
		write_reg(lrmt_pkg::REG_COEF_Q, 32'd0);
		write_reg(lrmt_pkg::REG_FIRST_TERM, 32'd5);
		write_reg(lrmt_pkg::REG_SECOND_TERM, 32'd7);
		write_reg(lrmt_pkg::REG_MODULUS, 32'd97);
		send_term(VB'(3));
		send_term(VB'(4));
		send_term(VB'(6));
		wait_drained();

		// Random phases, each under fresh register settings; one phase runs without gaps.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(lrmt_pkg::REG_COEF_P, draw_operand());
			write_reg(lrmt_pkg::REG_COEF_Q, draw_operand());
			write_reg(lrmt_pkg::REG_FIRST_TERM, draw_operand());
			write_reg(lrmt_pkg::REG_SECOND_TERM, draw_operand());
			write_reg(lrmt_pkg::REG_MODULUS, draw_modulus());
			calm <= (ph == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_term(draw_index());
			end
			wait_drained();
		end

		calm <= 1'b0;
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
